// ----- hdl/lds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lds_pkg
// Types and codes shared by the limit drive supervisor and its channels.
// ============================================================================
package lds_pkg;

    // Input item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_POLL  = 1'b1;

    // Tri-state sensor codes (code 3 also reads as unreadable)
    localparam logic [1:0] SENS_CLEAR  = 2'd0;
    localparam logic [1:0] SENS_SET    = 2'd1;
    localparam logic [1:0] SENS_UNREAD = 2'd2;
    localparam logic [1:0] SENS_UNREAD_ALT = 2'd3;

    // Motor commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_DRIVE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // End reasons
    localparam logic [2:0] RSN_DRIVING      = 3'd0;
    localparam logic [2:0] RSN_ALREADY_ON   = 3'd1;
    localparam logic [2:0] RSN_REACHED      = 3'd2;
    localparam logic [2:0] RSN_CANCELLED    = 3'd3;
    localparam logic [2:0] RSN_TIMEOUT      = 3'd4;
    localparam logic [2:0] RSN_NOT_ADVANCED = 3'd5;
    localparam logic [2:0] RSN_NEVER_MOVED  = 3'd6;
    localparam logic [2:0] RSN_LEG_LIMIT    = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_LEGS   = 2'd0;
    localparam logic [1:0] CFG_IDLE_NEED  = 2'd1;
    localparam logic [1:0] CFG_GRACE_MS   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_MS = 2'd3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    // Configuration reset values
    localparam logic [3:0]  RST_MAX_LEGS   = 4'd6;
    localparam logic [7:0]  RST_IDLE_NEED  = 8'd10;
    localparam logic [19:0] RST_GRACE_MS   = 20'd3000;
    localparam logic [19:0] RST_TIMEOUT_MS = 20'd180000;

    localparam logic [7:0]  IDLE_RUN_MAX = 8'hFF;

    typedef struct packed {
        logic               func;
        logic               to_high;
        logic [1:0]         low_switch;
        logic [1:0]         high_switch;
        logic [1:0]         moving;
        logic               counter_valid;
        logic signed [31:0] counter;
        logic               cancel_request;
        logic [19:0]        elapsed_ms;
    } t_lds_in;

    typedef struct packed {
        logic [1:0] command;
        logic       active;
        logic       finished;
        logic [2:0] reason;
        logic       reached_switch;
        logic       was_cancelled;
        logic [3:0] leg_number;
        logic [1:0] target_sensor;
        logic       on_switch;
    } t_lds_out;

endpackage
`default_nettype wire

// ----- hdl/lds_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lds_in_if
// Valid/ready channel carrying one sensor item into the supervisor.
// ============================================================================
interface lds_in_if
    import lds_pkg::*;
();
    logic    valid;
    logic    ready;
    t_lds_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/lds_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lds_out_if
// Valid/ready channel carrying one supervisor result item.
// ============================================================================
interface lds_out_if
    import lds_pkg::*;
();
    logic     valid;
    logic     ready;
    t_lds_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/limit_drive_supervisor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// limit_drive_supervisor
// Supervises an axis drive to an end switch, one result per sensor item.
// ============================================================================
//  Port       Dir  Handshake      Carries
//  i_in       in   valid/ready    start or poll sensor item (t_lds_in)
//  o_out      out  valid/ready    command and status result (t_lds_out)
//  i_cfg_*    in   write enable   register index and data, no read-back
//
//  One item per cycle while the output is not stalled: each transfer is decided
//  combinationally and its result is loaded into the output register at the
//  same edge, offered the next cycle. Input ready is high whenever the output
//  register is empty or being drained, so a stall on the output holds the input
//  only while a result is waiting. Synchronous active-low reset clears the
//  drive state and loads the register defaults.
// ============================================================================
module limit_drive_supervisor
    import lds_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    lds_in_if.sink                 i_in,
    lds_out_if.source              o_out,
    input  wire                    i_cfg_we,
    input  wire [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers
    logic [3:0]  r_max_legs;
    logic [7:0]  r_idle_need;
    logic [19:0] r_grace_ms;
    logic [19:0] r_timeout_ms;

    // Drive state
    logic                   r_active,    n_active;
    logic                   r_side_high, n_side_high;
    logic [COUNT_WIDTH-1:0] r_last,      n_last;
    logic                   r_have,      n_have;
    logic [COUNT_WIDTH-1:0] r_leg_start, n_leg_start;
    logic                   r_leg_had,   n_leg_had;
    logic [7:0]             r_idle_run,  n_idle_run;
    logic                   r_moved,     n_moved;
    logic [3:0]             r_leg,       n_leg;

    // Output register
    logic     r_out_valid;
    t_lds_out r_out, n_out;

    logic                   take;
    logic                   is_start;
    logic [1:0]             target;
    logic signed [63:0]     count_ext;
    logic [COUNT_WIDTH-1:0] count_now;
    logic                   advanced;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign take        = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_legs   <= RST_MAX_LEGS;
            r_idle_need  <= RST_IDLE_NEED;
            r_grace_ms   <= RST_GRACE_MS;
            r_timeout_ms <= RST_TIMEOUT_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_LEGS:   r_max_legs   <= i_cfg_data[3:0];
                CFG_IDLE_NEED:  r_idle_need  <= i_cfg_data[7:0];
                CFG_GRACE_MS:   r_grace_ms   <= i_cfg_data;
                CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sign-extend the counter and keep it at the stored width
    assign count_ext = 64'(i_in.data.counter);
    assign count_now = count_ext[COUNT_WIDTH-1:0];
    assign is_start  = (i_in.data.func == FUNC_START);

    // Decide one item
    always_comb begin
        n_active    = r_active;
        n_side_high = r_side_high;
        n_last      = r_last;
        n_have      = r_have;
        n_leg_start = r_leg_start;
        n_leg_had   = r_leg_had;
        n_idle_run  = r_idle_run;
        n_moved     = r_moved;
        n_leg       = r_leg;
        advanced    = 1'b0;

        n_out                = '0;
        n_out.command        = CMD_NONE;
        n_out.reason         = RSN_DRIVING;

        // A start drops whatever drive was running
        if (is_start) begin
            n_side_high = i_in.data.to_high;
            n_have      = 1'b0;
            n_last      = '0;
            n_leg       = '0;
            n_idle_run  = '0;
            n_moved     = 1'b0;
            n_leg_had   = 1'b0;
            n_leg_start = '0;
        end

        target = n_side_high ? i_in.data.high_switch : i_in.data.low_switch;

        // Take a good counter reading on a start or a live poll
        if ((is_start || r_active) && i_in.data.counter_valid) begin
            n_last = count_now;
            n_have = 1'b1;
        end

        if (is_start) begin
            if (target == SENS_SET) begin
                n_active             = 1'b0;
                n_out.finished       = 1'b1;
                n_out.reached_switch = 1'b1;
                n_out.reason         = RSN_ALREADY_ON;
            end else begin
                n_active      = 1'b1;
                n_leg         = n_leg + 4'd1;
                n_leg_start   = n_last;
                n_leg_had     = n_have;
                n_idle_run    = '0;
                n_moved       = 1'b0;
                n_out.command = CMD_DRIVE;
            end
        end else if (r_active) begin
            if (target == SENS_SET) begin
                n_out.command        = CMD_STOP;
                n_out.reason         = RSN_REACHED;
                n_out.reached_switch = 1'b1;
                n_out.finished       = 1'b1;
            end else if (i_in.data.cancel_request) begin
                n_out.command       = CMD_STOP;
                n_out.reason        = RSN_CANCELLED;
                n_out.was_cancelled = 1'b1;
                n_out.finished      = 1'b1;
            end else if (i_in.data.elapsed_ms > r_timeout_ms) begin
                n_out.command  = CMD_STOP;
                n_out.reason   = RSN_TIMEOUT;
                n_out.finished = 1'b1;
            end else begin
                // Track motion and the run of idle samples
                if (i_in.data.moving == SENS_SET) begin
                    n_moved = 1'b1;
                end
                if (i_in.data.moving == SENS_CLEAR) begin
                    if (r_idle_run != IDLE_RUN_MAX) begin
                        n_idle_run = r_idle_run + 8'd1;
                    end
                end else begin
                    n_idle_run = '0;
                end
                // End the leg once idle long enough, after motion was seen or the grace time passed
                if (n_idle_run >= r_idle_need &&
                    (n_moved || i_in.data.elapsed_ms > r_grace_ms)) begin
                    advanced = r_leg_had && n_have && (n_last != r_leg_start);
                    if (!advanced) begin
                        n_out.reason   = n_moved ? RSN_NOT_ADVANCED : RSN_NEVER_MOVED;
                        n_out.finished = 1'b1;
                    end else if (r_leg >= r_max_legs) begin
                        n_out.reason   = RSN_LEG_LIMIT;
                        n_out.finished = 1'b1;
                    end else begin
                        n_leg         = r_leg + 4'd1;
                        n_leg_start   = n_last;
                        n_leg_had     = n_have;
                        n_idle_run    = '0;
                        n_moved       = 1'b0;
                        n_out.command = CMD_DRIVE;
                    end
                end
            end
            if (n_out.finished) begin
                n_active = 1'b0;
            end
        end

        n_out.active        = n_active;
        n_out.leg_number    = n_leg;
        n_out.target_sensor = (target == SENS_UNREAD_ALT) ? SENS_UNREAD : target;
        n_out.on_switch     = (target == SENS_SET);
    end

    // Advance drive state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_side_high <= 1'b0;
            r_last      <= '0;
            r_have      <= 1'b0;
            r_leg_start <= '0;
            r_leg_had   <= 1'b0;
            r_idle_run  <= '0;
            r_moved     <= 1'b0;
            r_leg       <= '0;
        end else if (take) begin
            r_active    <= n_active;
            r_side_high <= n_side_high;
            r_last      <= n_last;
            r_have      <= n_have;
            r_leg_start <= n_leg_start;
            r_leg_had   <= n_leg_had;
            r_idle_run  <= n_idle_run;
            r_moved     <= n_moved;
            r_leg       <= n_leg;
        end
    end

    // Hold the result until the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
